// ===== hw/rtl/evxr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// evxr_pkg
// Types, constants and the first-quadrant sine table of the Euler XYZ core.
// ----------------------------------------------------------------------------
package evxr_pkg;

    localparam int AngW      = 14;
    localparam int AccW      = 16;
    localparam int CompW     = 17;
    localparam int CoefW     = 17;
    localparam int ZbW       = 10;
    localparam int RedW      = 13;          // reduced angle 0..5759
    localparam int SinIdxW   = 11;          // 0..1440
    localparam int SinDepth  = 1441;
    localparam int ProdW     = CompW + CoefW;
    localparam int SumW      = ProdW + 1;
    localparam int RotLat    = 4;
    localparam int QDepthDef = 2;

    localparam int FullTurn    = 5760;
    localparam int HalfTurn    = 2880;
    localparam int QuarterTurn = 1440;
    localparam int EighthTurn  = 720;
    localparam int OutLimit    = 56756;
    localparam logic [ZbW-1:0] ZbReset = ZbW'(1);

    localparam logic [63:0] PiQ62  = 64'hC90FDAA22168C234;
    localparam logic [63:0] OneQ62 = 64'h4000000000000000;
    localparam logic [63:0] PiStep = PiQ62 / 64'(HalfTurn);
    localparam logic [63:0] PiRem  = PiQ62 % 64'(HalfTurn);

    typedef struct packed {
        logic               neg_s;
        logic [SinIdxW-1:0] idx_s;
        logic               neg_c;
        logic [SinIdxW-1:0] idx_c;
    } t_trig;

    typedef struct packed {
        t_trig                   trig_x;
        t_trig                   trig_y;
        t_trig                   trig_z;
        logic signed [AccW-1:0]  acc_x;
        logic signed [AccW-1:0]  acc_y;
        logic signed [AccW-1:0]  acc_z;
    } t_job;

    typedef logic [SinDepth-1:0][CoefW-1:0] t_sin_rom;

    function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // shift-subtract quotient; only used while building the table
    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], num[i]};
            if (r >= {1'b0, den}) begin
                r = r - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [CoefW-1:0] series_q15(logic [63:0] k, logic want_sin);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] d;
        logic [63:0] rnd;
        x = PiStep * k + udiv64(PiRem * k, 64'(HalfTurn));
        term = want_sin ? x : OneQ62;
        sum = term;
        for (int n = 1; n <= 12; n++) begin
            d = want_sin ? 64'((2 * n) * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
            term = udiv64(mul_q62(mul_q62(term, x), x), d);
            if (n[0]) sum = sum - term;
            else      sum = sum + term;
        end
        rnd = (sum + (64'd1 << 46)) >> 47;
        return rnd[CoefW-1:0];
    endfunction

    function automatic t_sin_rom build_sin_rom();
        t_sin_rom rom;
        for (int k = 0; k < SinDepth; k++) begin
            if (k <= EighthTurn) rom[k] = series_q15(64'(k), 1'b1);
            else                 rom[k] = series_q15(64'(QuarterTurn - k), 1'b0);
        end
        return rom;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/euler_xyz_vector_rotation_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// euler_xyz_vector_rotation_core
// Rotates an acceleration vector about X, then Y, then Z.
// ----------------------------------------------------------------------------
// A request is taken on any cycle with i_start high and o_busy low; o_busy
// stays low in use, so one request a cycle is sustained. Each result appears
// for one cycle with o_done, after its request has passed two front stages,
// the queue and three four-stage rotation units, each led by a registered
// sine table read. Results cannot be held off. Write i_cfg_data with
// i_cfg_we only while no requests are in flight.
// ----------------------------------------------------------------------------
module euler_xyz_vector_rotation_core
    import evxr_pkg::*;
#(
    parameter int QDEPTH = QDepthDef
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    output logic                         o_busy,
    input  wire logic                    i_cfg_we,
    input  wire logic [ZbW-1:0]          i_cfg_data,
    input  wire logic signed [AngW-1:0]  i_angle_x,
    input  wire logic signed [AngW-1:0]  i_angle_y,
    input  wire logic signed [AngW-1:0]  i_angle_z,
    input  wire logic signed [AccW-1:0]  i_acc_x,
    input  wire logic signed [AccW-1:0]  i_acc_y,
    input  wire logic signed [AccW-1:0]  i_acc_z,
    output logic                         o_done,
    output logic signed [CompW-1:0]      o_rot_x,
    output logic signed [CompW-1:0]      o_rot_y,
    output logic signed [CompW-1:0]      o_rot_z
);

    logic [ZbW-1:0] r_zero_band;
    logic           take, f_valid, q_valid, q_full;
    t_job           f_job, q_job;
    t_trig          r_ty_dly [RotLat];
    t_trig          r_tz_dly [2*RotLat];

    logic                    v1, v2, v3;
    logic signed [CompW-1:0] y1, z1, x1, z2, x2, y2, x3, y3, z3;

    assign take   = i_start && !o_busy;
    assign o_busy = q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_zero_band <= ZbReset;
        else if (i_cfg_we) r_zero_band <= i_cfg_data;
    end

    evxr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_angle_x (i_angle_x),
        .i_angle_y (i_angle_y),
        .i_angle_z (i_angle_z),
        .i_acc_x   (i_acc_x),
        .i_acc_y   (i_acc_y),
        .i_acc_z   (i_acc_z),
        .o_valid   (f_valid),
        .o_job     (f_job)
    );

    evxr_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_job   (f_job),
        .o_valid (q_valid),
        .o_job   (q_job),
        .o_full  (q_full)
    );

    // later angles ride alongside the earlier rotation units
    always_ff @(posedge i_clk) begin
        r_ty_dly[0] <= q_job.trig_y;
        for (int i = 1; i < RotLat; i++) r_ty_dly[i] <= r_ty_dly[i-1];
        r_tz_dly[0] <= q_job.trig_z;
        for (int i = 1; i < 2*RotLat; i++) r_tz_dly[i] <= r_tz_dly[i-1];
    end

    evxr_rot u_rot_x (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_trig      (q_job.trig_x),
        .i_p         (CompW'(q_job.acc_y)),
        .i_q         (CompW'(q_job.acc_z)),
        .i_r         (CompW'(q_job.acc_x)),
        .i_zero_band (r_zero_band),
        .o_valid     (v1),
        .o_p         (y1),
        .o_q         (z1),
        .o_r         (x1)
    );

    evxr_rot u_rot_y (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (v1),
        .i_trig      (r_ty_dly[RotLat-1]),
        .i_p         (z1),
        .i_q         (x1),
        .i_r         (y1),
        .i_zero_band (r_zero_band),
        .o_valid     (v2),
        .o_p         (z2),
        .o_q         (x2),
        .o_r         (y2)
    );

    evxr_rot u_rot_z (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (v2),
        .i_trig      (r_tz_dly[2*RotLat-1]),
        .i_p         (x2),
        .i_q         (y2),
        .i_r         (z2),
        .i_zero_band (r_zero_band),
        .o_valid     (v3),
        .o_p         (x3),
        .o_q         (y3),
        .o_r         (z3)
    );

    assign o_done  = v3;
    assign o_rot_x = x3;
    assign o_rot_y = y3;
    assign o_rot_z = z3;

endmodule
`default_nettype wire

// ===== hw/rtl/evxr_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// evxr_front
// Takes requests, reduces each angle to one turn and folds it to a quadrant
// index and sign for sine and cosine. Two register stages.
// ----------------------------------------------------------------------------
module evxr_front
    import evxr_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_take,
    input  wire logic signed [AngW-1:0] i_angle_x,
    input  wire logic signed [AngW-1:0] i_angle_y,
    input  wire logic signed [AngW-1:0] i_angle_z,
    input  wire logic signed [AccW-1:0] i_acc_x,
    input  wire logic signed [AccW-1:0] i_acc_y,
    input  wire logic signed [AccW-1:0] i_acc_z,
    output logic                        o_valid,
    output t_job                        o_job
);

    logic                   r_va, r_vb;
    logic [RedW-1:0]        r_ax, r_ay, r_az;
    logic signed [AccW-1:0] r_px, r_py, r_pz;
    t_job                   r_job;

    function automatic logic [RedW-1:0] reduce(logic signed [AngW-1:0] ang);
        logic signed [AngW+1:0] a;
        a = (AngW+2)'(ang);
        if (a < -(AngW+2)'(FullTurn))     a = a + (AngW+2)'(2 * FullTurn);
        else if (a < 0)                   a = a + (AngW+2)'(FullTurn);
        else if (a >= (AngW+2)'(FullTurn)) a = a - (AngW+2)'(FullTurn);
        return a[RedW-1:0];
    endfunction

    // quadrant fold: index into the first-quadrant table plus sign
    function automatic logic [SinIdxW:0] fold(logic [RedW-1:0] a);
        logic [RedW-1:0] k;
        logic            neg;
        if (a < RedW'(QuarterTurn)) begin
            k = a; neg = 1'b0;
        end else if (a < RedW'(HalfTurn)) begin
            k = RedW'(HalfTurn) - a; neg = 1'b0;
        end else if (a < RedW'(HalfTurn + QuarterTurn)) begin
            k = a - RedW'(HalfTurn); neg = 1'b1;
        end else begin
            k = RedW'(FullTurn) - a; neg = 1'b1;
        end
        return {neg, k[SinIdxW-1:0]};
    endfunction

    function automatic t_trig make_trig(logic [RedW-1:0] a);
        logic [RedW:0]    ac;
        logic [SinIdxW:0] fs, fc;
        t_trig            t;
        ac = {1'b0, a} + (RedW+1)'(QuarterTurn);
        if (ac >= (RedW+1)'(FullTurn)) ac = ac - (RedW+1)'(FullTurn);
        fs = fold(a);
        fc = fold(ac[RedW-1:0]);
        t.neg_s = fs[SinIdxW];
        t.idx_s = fs[SinIdxW-1:0];
        t.neg_c = fc[SinIdxW];
        t.idx_c = fc[SinIdxW-1:0];
        return t;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= i_take;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ax <= reduce(i_angle_x);
        r_ay <= reduce(i_angle_y);
        r_az <= reduce(i_angle_z);
        r_px <= i_acc_x;
        r_py <= i_acc_y;
        r_pz <= i_acc_z;
        r_job.trig_x <= make_trig(r_ax);
        r_job.trig_y <= make_trig(r_ay);
        r_job.trig_z <= make_trig(r_az);
        r_job.acc_x  <= r_px;
        r_job.acc_y  <= r_py;
        r_job.acc_z  <= r_pz;
    end

    assign o_valid = r_vb;
    assign o_job   = r_job;

endmodule
`default_nettype wire

// ===== hw/rtl/evxr_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// evxr_queue
// Short FIFO between front and back; the back drains one entry a cycle.
// ----------------------------------------------------------------------------
module evxr_queue
    import evxr_pkg::*;
#(
    parameter int DEPTH = QDepthDef
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_valid,
    output t_job      o_job,
    output logic      o_full
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [PtrW-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            pop;

    assign pop = (r_cnt != '0);

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) n_wr = (r_wr == PtrW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        if (pop)    n_rd = (r_rd == PtrW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        if (i_push && !pop)      n_cnt = r_cnt + 1'b1;
        else if (!i_push && pop) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

    assign o_valid = pop;
    assign o_job   = r_mem[r_rd];
    assign o_full  = (r_cnt == CntW'(DEPTH));

endmodule
`default_nettype wire

// ===== hw/rtl/evxr_rot.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// evxr_rot
// One plane rotation: table read, four products, sums, then rounding of the
// two rotated components, saturation and dead zone on all three. Four stages.
// ----------------------------------------------------------------------------
module evxr_rot
    import evxr_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire t_trig                   i_trig,
    input  wire logic signed [CompW-1:0] i_p,
    input  wire logic signed [CompW-1:0] i_q,
    input  wire logic signed [CompW-1:0] i_r,
    input  wire logic        [ZbW-1:0]   i_zero_band,
    output logic                         o_valid,
    output logic signed [CompW-1:0]      o_p,
    output logic signed [CompW-1:0]      o_q,
    output logic signed [CompW-1:0]      o_r
);

    localparam t_sin_rom SinRom = build_sin_rom();

    logic [RotLat-1:0]       r_v;
    logic [CoefW-1:0]        r_smag, r_cmag;
    logic                    r_sneg, r_cneg;
    logic signed [CompW-1:0] r_p1, r_q1, r_r1, r_r2, r_r3;
    logic signed [ProdW-1:0] r_cp, r_sq, r_sp, r_cq;
    logic signed [SumW-1:0]  r_np, r_nq;
    logic signed [CompW-1:0] r_op, r_oq, r_or;
    logic signed [CoefW-1:0] s, c;

    function automatic logic signed [CompW-1:0] finish(logic signed [SumW-1:0] v,
                                                       logic is_int,
                                                       logic [ZbW-1:0] zb);
        logic [SumW-1:0] mag;
        logic [SumW-1:0] m;
        logic [CompW-1:0] res;
        mag = v[SumW-1] ? SumW'(-v) : SumW'(v);
        m = is_int ? mag : ((mag + SumW'(16384)) >> 15);
        if (m > SumW'(OutLimit)) m = SumW'(OutLimit);
        if (m < SumW'(zb))       m = '0;
        res = m[CompW-1:0];
        return v[SumW-1] ? CompW'(-res) : CompW'(res);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else          r_v <= {r_v[RotLat-2:0], i_valid};
    end

    // magnitudes up to 32768 fit the 17-bit signed coefficient
    assign s = r_sneg ? -$signed(r_smag) : $signed(r_smag);
    assign c = r_cneg ? -$signed(r_cmag) : $signed(r_cmag);

    always_ff @(posedge i_clk) begin
        r_smag <= SinRom[i_trig.idx_s];
        r_cmag <= SinRom[i_trig.idx_c];
        r_sneg <= i_trig.neg_s;
        r_cneg <= i_trig.neg_c;
        r_p1   <= i_p;
        r_q1   <= i_q;
        r_r1   <= i_r;

        r_cp <= ProdW'(c * r_p1);
        r_sq <= ProdW'(s * r_q1);
        r_sp <= ProdW'(s * r_p1);
        r_cq <= ProdW'(c * r_q1);
        r_r2 <= r_r1;

        r_np <= SumW'(r_cp) - SumW'(r_sq);
        r_nq <= SumW'(r_sp) + SumW'(r_cq);
        r_r3 <= r_r2;

        r_op <= finish(r_np, 1'b0, i_zero_band);
        r_oq <= finish(r_nq, 1'b0, i_zero_band);
        r_or <= finish(SumW'(r_r3), 1'b1, i_zero_band);
    end

    assign o_valid = r_v[RotLat-1];
    assign o_p     = r_op;
    assign o_q     = r_oq;
    assign o_r     = r_or;

endmodule
`default_nettype wire
